### rtl/hfvn_pkg.sv
// Shared types, constants and helpers of the heightfield vertex normal block.
package hfvn_pkg;

  localparam int H_W     = 16;
  localparam int STEP_W  = 16;
  localparam int GCOLS_W = 13;
  localparam int ROWS_W  = 16;
  localparam int SUM_W   = 20;
  localparam int Q_W     = 16;
  localparam int VEC_W   = 42;
  localparam int VCOL_W  = 12;
  localparam int CFG_W   = 16;

  localparam logic signed [SUM_W-1:0] SUM_LIM = 20'sd524287;
  localparam logic signed [SUM_W:0]   SUM_HI  = 21'sd524287;
  localparam logic signed [SUM_W:0]   SUM_LO  = -21'sd524287;
  localparam logic [Q_W-1:0]          ONE_Q14 = 16'd16384;

  typedef enum logic [1:0] {
    CFG_STEP_X    = 2'd0,
    CFG_STEP_Y    = 2'd1,
    CFG_GRID_COLS = 2'd2,
    CFG_GRID_ROWS = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MUL_AX = 3'd0,
    MUL_AY = 3'd1,
    MUL_Z  = 3'd2,
    MUL_BX = 3'd3,
    MUL_BY = 3'd4
  } mul_op_e;

  // Corners of the current cell: upper-left, upper-right, lower-left, lower-right
  typedef enum logic [1:0] {
    SLOT_UL = 2'd0,
    SLOT_UR = 2'd1,
    SLOT_LL = 2'd2,
    SLOT_LR = 2'd3
  } slot_e;

  typedef logic [2:0][VEC_W-1:0] vec3_t;
  typedef logic [2:0][Q_W-1:0]   q3_t;

  typedef struct packed {
    logic    take_in;
    logic    clr;
    logic    up_ld;
    logic    mul_en;
    mul_op_e mul_op;
    logic    u_start;
    logic    fa_ld;
    logic    fb_ld;
    logic    acc_wr;
    logic    upd;
    logic    vec_ld_sum;
    logic    out_ld;
    logic    last_item;
    slot_e   slot;
  } dp_cmd_t;

  typedef struct packed {
    logic       has_facets;
    logic [3:0] emit_mask;
    logic       u_done;
  } dp_sts_t;

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                      input logic signed [Q_W-1:0] f);
    logic signed [SUM_W:0] t;
    t = (SUM_W+1)'(s) + (SUM_W+1)'(f);
    if (t > SUM_HI) begin
      return SUM_LIM;
    end else if (t < SUM_LO) begin
      return -SUM_LIM;
    end
    return t[SUM_W-1:0];
  endfunction

endpackage

### rtl/hfvn_if.sv
// Stream channels of the block: height samples in, vertex normals out.
interface hfvn_in_if import hfvn_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [H_W-1:0] height;
  logic                  first_sample;

  modport source (output valid, output height, output first_sample, input ready);
  modport sink   (input valid, input height, input first_sample, output ready);
endinterface

interface hfvn_out_if import hfvn_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [Q_W-1:0] norm_x;
  logic signed [Q_W-1:0] norm_y;
  logic signed [Q_W-1:0] norm_z;
  logic [VCOL_W-1:0]     vert_col;
  logic [ROWS_W-1:0]     vert_row;
  logic                  last_of_item;
  logic                  last_of_grid;

  modport source (output valid, output norm_x, output norm_y, output norm_z, output vert_col,
                  output vert_row, output last_of_item, output last_of_grid, input ready);
  modport sink   (input valid, input norm_x, input norm_y, input norm_z, input vert_col,
                  input vert_row, input last_of_item, input last_of_grid, output ready);
endinterface

### rtl/heightfield_vertex_normals_core.sv
// Top level of the streaming heightfield vertex normal block.
//
// Usage: heights enter on sample_i in raster order, west to east, north to
// south; first_sample marks the north-west corner and restarts the position
// counters. Each transfer on normal_o carries one Q2.14 unit vertex normal
// with its column and row, last_of_item on the last result of a sample and
// last_of_grid on the south-east vertex. A sample causes zero to four results.
// Registers step_x, step_y, grid_cols and grid_rows are written through the
// cfg port (index 0 to 3), by the user only while idle; the block won't check.
//
// Throughput: one sample at a time. The shared unit vector unit sets the pace:
// one normalisation runs scaling shifts, squares, a square root and three
// 16-step divisions. A sample that finishes a cell takes two normalisations
// for its facets, then each result takes one more normalisation; a sample that
// neither finishes a cell nor completes a vertex takes none.
// Reset returns the steps to 1.0, the grid to 2 x 2 and the counters to the
// north-west corner; the row buffers are not cleared. While the receiver
// stalls, the result is held on normal_o and no new sample is taken.
module heightfield_vertex_normals_core import hfvn_pkg::*; #(
  parameter int MAX_COLS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  hfvn_in_if.sink           sample_i,
  hfvn_out_if.source        normal_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Controller: hold the result until its transfer, then advance to the next
  hfvn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (normal_o.valid),
    .out_ready_i (normal_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: row buffers, facet products, corner sums and unit vector unit
  hfvn_dp #(.MAX_COLS(MAX_COLS)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .height_i       (sample_i.height),
    .first_sample_i (sample_i.first_sample),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .norm_x_o       (normal_o.norm_x),
    .norm_y_o       (normal_o.norm_y),
    .norm_z_o       (normal_o.norm_z),
    .vert_col_o     (normal_o.vert_col),
    .vert_row_o     (normal_o.vert_row),
    .last_of_item_o (normal_o.last_of_item),
    .last_of_grid_o (normal_o.last_of_grid)
  );

endmodule

### rtl/hfvn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hfvn_ram #(
  parameter int W = 16,
  parameter int D = 4096
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/hfvn_norm.sv
// Sequential unit vector unit: scale, sum of squares, square root, three divisions.
module hfvn_norm import hfvn_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  vec3_t vec_i,
  output logic  done_o,
  output q3_t   res_o
);

  typedef enum logic [5:0] {
    U_IDLE = 6'b000001,
    U_NORM = 6'b000010,
    U_SQ   = 6'b000100,
    U_SQRT = 6'b001000,
    U_DIVI = 6'b010000,
    U_DIV  = 6'b100000
  } ust_e;

  ust_e        st_q;
  logic        done_q;
  logic [1:0]  idx_q;
  logic [3:0]  cnt_q;
  vec3_t       mag_q;
  logic [2:0]  sgn_q;
  logic [61:0] acc_q;
  logic [63:0] x_q, res_q, bit_q;
  logic [31:0] rem_q;
  logic [15:0] nlo_q, quo_q;
  q3_t         out_q;

  logic [VEC_W-1:0] m01, m;
  logic [31:0]      len;
  logic [59:0]      sq;
  logic [63:0]      rb;
  logic             ge;
  logic [45:0]      ndiv;
  logic [32:0]      t;
  logic             tge;
  logic [15:0]      qn, qc;
  logic             scale_ok;

  always_comb begin
    m01      = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
    m        = (m01 > mag_q[2]) ? m01 : mag_q[2];
    scale_ok = (m[VEC_W-1:30] == '0) && m[29];
    len      = res_q[31:0];
    sq       = mag_q[idx_q][29:0] * mag_q[idx_q][29:0];
    rb       = res_q + bit_q;
    ge       = x_q >= rb;
    ndiv     = {2'b00, mag_q[idx_q][29:0], 14'b0} + 46'(len[31:1]);
    t        = {rem_q, nlo_q[cnt_q]};
    tge      = t >= {1'b0, len};
    qn       = {quo_q[14:0], tge};
    qc       = (qn > ONE_Q14) ? ONE_Q14 : qn;
  end

  // Control: sequence and iteration counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= U_IDLE;
      done_q <= 1'b0;
      idx_q  <= '0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        U_IDLE: begin
          if (start_i) begin
            st_q <= U_NORM;
          end
        end
        U_NORM: begin
          if (m == '0) begin
            st_q   <= U_IDLE;
            done_q <= 1'b1;
          end else if (scale_ok) begin
            st_q  <= U_SQ;
            idx_q <= '0;
          end
        end
        U_SQ: begin
          if (idx_q == 2'd2) begin
            st_q <= U_SQRT;
          end else begin
            idx_q <= idx_q + 2'd1;
          end
        end
        U_SQRT: begin
          if (bit_q[0]) begin
            st_q  <= U_DIVI;
            idx_q <= '0;
          end
        end
        U_DIVI: begin
          st_q  <= U_DIV;
          cnt_q <= 4'd15;
        end
        U_DIV: begin
          if (cnt_q == '0) begin
            if (idx_q == 2'd2) begin
              st_q   <= U_IDLE;
              done_q <= 1'b1;
            end else begin
              idx_q <= idx_q + 2'd1;
              st_q  <= U_DIVI;
            end
          end else begin
            cnt_q <= cnt_q - 4'd1;
          end
        end
        default: st_q <= U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      U_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            sgn_q[i] <= vec_i[i][VEC_W-1];
            mag_q[i] <= vec_i[i][VEC_W-1] ? (~vec_i[i] + 1'b1) : vec_i[i];
          end
        end
      end
      U_NORM: begin
        if (m == '0) begin
          out_q <= '0;
        end else if (m[VEC_W-1:30] != '0) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
        end else if (!m[29]) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
        end else begin
          acc_q <= '0;
        end
      end
      U_SQ: begin
        acc_q <= acc_q + 62'(sq);
        if (idx_q == 2'd2) begin
          x_q   <= 64'(acc_q + 62'(sq));
          res_q <= '0;
          bit_q <= 64'd1 << 62;
        end
      end
      U_SQRT: begin
        if (ge) begin
          x_q   <= x_q - rb;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      U_DIVI: begin
        rem_q <= 32'(ndiv[45:16]);
        nlo_q <= ndiv[15:0];
        quo_q <= '0;
      end
      U_DIV: begin
        rem_q <= tge ? 32'(t - {1'b0, len}) : t[31:0];
        quo_q <= qn;
        if (cnt_q == '0) begin
          out_q[idx_q] <= sgn_q[idx_q] ? (16'd0 - qc) : qc;
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = out_q;

endmodule

### rtl/hfvn_dp.sv
// Datapath: configuration, position counters, row buffers, facet products, sums.
module hfvn_dp import hfvn_pkg::*; #(
  parameter int MAX_COLS = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_data_i,
  input  logic signed [H_W-1:0]    height_i,
  input  logic                     first_sample_i,
  input  dp_cmd_t                  cmd_i,
  output dp_sts_t                  sts_o,
  output logic signed [Q_W-1:0]    norm_x_o,
  output logic signed [Q_W-1:0]    norm_y_o,
  output logic signed [Q_W-1:0]    norm_z_o,
  output logic [VCOL_W-1:0]        vert_col_o,
  output logic [ROWS_W-1:0]        vert_row_o,
  output logic                     last_of_item_o,
  output logic                     last_of_grid_o
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int AW = CW + 1;

  logic [STEP_W-1:0]  step_x_q, step_y_q;
  logic [GCOLS_W-1:0] grid_cols_q;
  logic [ROWS_W-1:0]  grid_rows_q;

  logic [CW-1:0]     col_pos_q, c_q, last_col, col_k;
  logic [ROWS_W-1:0] row_pos_q, r_q, last_row, row_k;
  logic signed [H_W-1:0] h_q, prev_q, ul_q, up_q;
  logic [H_W-1:0]    hram_rd;

  logic [AW-1:0]          saddr;
  logic [3*SUM_W-1:0]     sum_rd, acc_val;
  logic signed [SUM_W-1:0] s_c [3];
  logic signed [SUM_W-1:0] t1 [3];
  logic signed [SUM_W-1:0] t2 [3];

  logic signed [16:0] ma, mb;
  logic signed [33:0] prod;
  vec3_t vec_q;
  q3_t   fa_q, fb_q, u_res;
  logic  u_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_x_q    <= 16'd256;
      step_y_q    <= 16'd256;
      grid_cols_q <= 13'd2;
      grid_rows_q <= 16'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_STEP_X:    step_x_q    <= cfg_data_i;
        CFG_STEP_Y:    step_y_q    <= cfg_data_i;
        CFG_GRID_COLS: grid_cols_q <= cfg_data_i[GCOLS_W-1:0];
        CFG_GRID_ROWS: grid_rows_q <= cfg_data_i[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective grid limits: zero acts as one, columns clamp to the buffer depth
  always_comb begin
    if (grid_cols_q == '0) begin
      last_col = '0;
    end else if (32'(grid_cols_q) > MAX_COLS) begin
      last_col = CW'(MAX_COLS - 1);
    end else begin
      last_col = CW'(grid_cols_q - 13'd1);
    end
    last_row = (grid_rows_q == '0) ? '0 : grid_rows_q - 16'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q <= '0;
      row_pos_q <= '0;
      prev_q    <= '0;
      ul_q      <= '0;
    end else if (cmd_i.upd) begin
      prev_q <= h_q;
      ul_q   <= up_q;
      if (c_q == last_col) begin
        col_pos_q <= '0;
        row_pos_q <= (r_q == last_row) ? '0 : r_q + 16'd1;
      end else begin
        col_pos_q <= c_q + 1'b1;
        row_pos_q <= r_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      h_q <= height_i;
      c_q <= first_sample_i ? '0 : ((col_pos_q <= last_col) ? col_pos_q : last_col);
      r_q <= first_sample_i ? '0 : ((row_pos_q <= last_row) ? row_pos_q : last_row);
    end
    if (cmd_i.up_ld) begin
      up_q <= $signed(hram_rd);
    end
  end

  hfvn_ram #(.W(H_W), .D(MAX_COLS)) u_hram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.upd),
    .waddr_i (c_q),
    .wdata_i (h_q),
    .raddr_i (c_q),
    .rdata_o (hram_rd)
  );

  // Corner of the cell picked by the slot code; row parity picks the row buffer
  always_comb begin
    col_k = (cmd_i.slot == SLOT_UL || cmd_i.slot == SLOT_LL) ? c_q - 1'b1 : c_q;
    row_k = (cmd_i.slot == SLOT_UL || cmd_i.slot == SLOT_UR) ? r_q - 16'd1 : r_q;
    saddr = {row_k[0], col_k};
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_c[i] = $signed(sum_rd[i*SUM_W +: SUM_W]);
      t1[i]  = (cmd_i.slot != SLOT_LR) ? sat_add(s_c[i], $signed(fa_q[i])) : s_c[i];
      t2[i]  = (cmd_i.slot != SLOT_UL) ? sat_add(t1[i], $signed(fb_q[i])) : t1[i];
      acc_val[i*SUM_W +: SUM_W] = t2[i];
    end
  end

  hfvn_ram #(.W(3*SUM_W), .D(2**AW)) u_sram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr | cmd_i.acc_wr),
    .waddr_i (saddr),
    .wdata_i (cmd_i.clr ? '0 : acc_val),
    .raddr_i (saddr),
    .rdata_o (sum_rd)
  );

  // One shared multiplier builds the facet components one at a time
  always_comb begin
    case (cmd_i.mul_op)
      MUL_AX: begin
        ma = 17'(ul_q) - 17'(up_q);
        mb = {1'b0, step_y_q};
      end
      MUL_AY: begin
        ma = 17'(ul_q) - 17'(prev_q);
        mb = {1'b0, step_x_q};
      end
      MUL_Z: begin
        ma = {1'b0, step_x_q};
        mb = {1'b0, step_y_q};
      end
      MUL_BX: begin
        ma = 17'(prev_q) - 17'(h_q);
        mb = {1'b0, step_y_q};
      end
      MUL_BY: begin
        ma = 17'(up_q) - 17'(h_q);
        mb = {1'b0, step_x_q};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod = ma * mb;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_op)
        MUL_AX, MUL_BX: vec_q[0] <= {prod, 8'b0};
        MUL_AY, MUL_BY: vec_q[1] <= {prod, 8'b0};
        MUL_Z:          vec_q[2] <= VEC_W'(prod);
        default: ;
      endcase
    end else if (cmd_i.vec_ld_sum) begin
      for (int i = 0; i < 3; i++) vec_q[i] <= VEC_W'(s_c[i]);
    end
    if (cmd_i.fa_ld) fa_q <= u_res;
    if (cmd_i.fb_ld) fb_q <= u_res;
    if (cmd_i.out_ld) begin
      norm_x_o       <= u_res[0];
      norm_y_o       <= u_res[1];
      norm_z_o       <= u_res[2];
      vert_col_o     <= VCOL_W'(col_k);
      vert_row_o     <= row_k;
      last_of_item_o <= cmd_i.last_item;
      last_of_grid_o <= (cmd_i.slot == SLOT_LR);
    end
  end

  hfvn_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.u_start),
    .vec_i   (vec_q),
    .done_o  (u_done),
    .res_o   (u_res)
  );

  always_comb begin
    sts_o.has_facets   = (r_q != '0) && (c_q != '0);
    sts_o.emit_mask[0] = (r_q != '0) && (c_q != '0);
    sts_o.emit_mask[1] = (r_q != '0) && (c_q == last_col);
    sts_o.emit_mask[2] = (r_q == last_row) && (c_q != '0);
    sts_o.emit_mask[3] = (r_q == last_row) && (c_q == last_col);
    sts_o.u_done       = u_done;
  end

endmodule

### rtl/hfvn_ctrl.sv
// Controller: sequences accept, facet build, corner updates and result transfers.
module hfvn_ctrl import hfvn_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [20:0] {
    S_IDLE  = 21'h000001,
    S_RDH   = 21'h000002,
    S_UP    = 21'h000004,
    S_MAX   = 21'h000008,
    S_MAY   = 21'h000010,
    S_MZ    = 21'h000020,
    S_UA    = 21'h000040,
    S_WA    = 21'h000080,
    S_MBX   = 21'h000100,
    S_MBY   = 21'h000200,
    S_UB    = 21'h000400,
    S_WB    = 21'h000800,
    S_ARD   = 21'h001000,
    S_AWR   = 21'h002000,
    S_UPD   = 21'h004000,
    S_EPICK = 21'h008000,
    S_ERD   = 21'h010000,
    S_ELD   = 21'h020000,
    S_EST   = 21'h040000,
    S_EW    = 21'h080000,
    S_OUT   = 21'h100000
  } st_e;

  st_e        st_q, st_d;
  slot_e      slot_q, slot_d;
  logic [3:0] mask_q, mask_d, mask_rest;

  function automatic slot_e lowest(input logic [3:0] m);
    if (m[0]) return SLOT_UL;
    if (m[1]) return SLOT_UR;
    if (m[2]) return SLOT_LL;
    return SLOT_LR;
  endfunction

  assign mask_rest = mask_q & ~(4'b0001 << slot_q);

  always_comb begin
    st_d   = st_q;
    slot_d = slot_q;
    mask_d = mask_q;
    cmd_o  = '0;
    cmd_o.slot = slot_q;
    case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          st_d = S_RDH;
        end
      end
      S_RDH: begin
        cmd_o.clr  = 1'b1;
        cmd_o.slot = SLOT_LR;
        st_d = S_UP;
      end
      S_UP: begin
        cmd_o.up_ld = 1'b1;
        st_d = sts_i.has_facets ? S_MAX : S_UPD;
      end
      S_MAX: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_AX;
        st_d = S_MAY;
      end
      S_MAY: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_AY;
        st_d = S_MZ;
      end
      S_MZ: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_Z;
        st_d = S_UA;
      end
      S_UA: begin
        cmd_o.u_start = 1'b1;
        st_d = S_WA;
      end
      S_WA: begin
        if (sts_i.u_done) begin
          cmd_o.fa_ld = 1'b1;
          st_d = S_MBX;
        end
      end
      S_MBX: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_BX;
        st_d = S_MBY;
      end
      S_MBY: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_BY;
        st_d = S_UB;
      end
      S_UB: begin
        cmd_o.u_start = 1'b1;
        st_d = S_WB;
      end
      S_WB: begin
        if (sts_i.u_done) begin
          cmd_o.fb_ld = 1'b1;
          slot_d = SLOT_UL;
          st_d = S_ARD;
        end
      end
      S_ARD: st_d = S_AWR;
      S_AWR: begin
        cmd_o.acc_wr = 1'b1;
        if (slot_q == SLOT_LR) begin
          st_d = S_UPD;
        end else begin
          slot_d = slot_e'(slot_q + 2'd1);
          st_d = S_ARD;
        end
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        mask_d = sts_i.emit_mask;
        st_d = S_EPICK;
      end
      S_EPICK: begin
        if (mask_q == '0) begin
          st_d = S_IDLE;
        end else begin
          slot_d = lowest(mask_q);
          st_d = S_ERD;
        end
      end
      S_ERD: st_d = S_ELD;
      S_ELD: begin
        cmd_o.vec_ld_sum = 1'b1;
        st_d = S_EST;
      end
      S_EST: begin
        cmd_o.u_start = 1'b1;
        st_d = S_EW;
      end
      S_EW: begin
        if (sts_i.u_done) begin
          cmd_o.out_ld    = 1'b1;
          cmd_o.last_item = (mask_rest == '0);
          mask_d = mask_rest;
          st_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          st_d = S_EPICK;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      slot_q <= SLOT_UL;
      mask_q <= '0;
    end else begin
      st_q   <= st_d;
      slot_q <= slot_d;
      mask_q <= mask_d;
    end
  end

  assign in_ready_o  = (st_q == S_IDLE);
  assign out_valid_o = (st_q == S_OUT);

endmodule
